[src/skt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key table package
// Sizes, operation and status codes, cell commands and a shared one-hot encoder.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int DEPTH        = 64;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int POS_BITS     = $clog2(DEPTH);
    localparam int CNT_BITS     = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_PUT     = 3'd0,
        MODE_FIND    = 3'd1,
        MODE_READ    = 3'd2,
        MODE_RM_POS  = 3'd3,
        MODE_RM_KEY  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_NOKEY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD_NEW,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT,
        CELL_SET_PAYLOAD
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        logic      cmp_en;
        logic      valid;
    } t_cell_ctl;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cell_flags;

    function automatic logic [POS_BITS-1:0] f_onehot_enc(input logic [DEPTH-1:0] v);
        logic [POS_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (v[i]) begin
                r = r | POS_BITS'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[src/skt_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key table cell
// Holds one entry, compares it against a search key and takes a new entry,
// its left or right neighbor's entry or a new payload on command.
// ----------------------------------------------------------------------------
module skt_cell (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire skt_pkg::t_cell_ctl              i_ctl,
    input  wire logic [skt_pkg::KEY_BITS-1:0]     i_cmp_key,
    input  wire logic [skt_pkg::KEY_BITS-1:0]     i_new_key,
    input  wire logic [skt_pkg::PAYLOAD_BITS-1:0] i_new_payload,
    input  wire logic [skt_pkg::KEY_BITS-1:0]     i_left_key,
    input  wire logic [skt_pkg::PAYLOAD_BITS-1:0] i_left_payload,
    input  wire logic [skt_pkg::KEY_BITS-1:0]     i_right_key,
    input  wire logic [skt_pkg::PAYLOAD_BITS-1:0] i_right_payload,
    output logic      [skt_pkg::KEY_BITS-1:0]     o_key,
    output logic      [skt_pkg::PAYLOAD_BITS-1:0] o_payload,
    output skt_pkg::t_cell_flags                 o_flags
);
    import skt_pkg::*;

    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_payload;
    t_cell_flags             r_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_ctl.cmp_en) begin
            r_flags.lt <= i_ctl.valid && (r_key < i_cmp_key);
            r_flags.eq <= i_ctl.valid && (r_key == i_cmp_key);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.cmd)
            CELL_HOLD: begin
            end
            CELL_LOAD_NEW: begin
                r_key     <= i_new_key;
                r_payload <= i_new_payload;
            end
            CELL_FROM_LEFT: begin
                r_key     <= i_left_key;
                r_payload <= i_left_payload;
            end
            CELL_FROM_RIGHT: begin
                r_key     <= i_right_key;
                r_payload <= i_right_payload;
            end
            CELL_SET_PAYLOAD: begin
                r_payload <= i_new_payload;
            end
            default: begin
            end
        endcase
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;
    assign o_flags   = r_flags;

endmodule
`default_nettype wire

[src/sorted_key_table_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key table core
// Keeps up to DEPTH entries sorted by ascending key in a chain of cells and
// performs put, find, read, remove by position and remove by key.
//
//   Channel   Direction   Handshake                   Fields
//   input     in          i_in_valid / o_in_stall     mode key position payload
//   output    out         o_out_valid / i_out_stall   status hit where_found
//                                                     key_out payload_out
//                                                     entry_count
//
// In the transfer cycle of an operation all cells compare their key against
// the search key and register the flags; then, once the result register is
// free or being emptied, the chain shifts or updates and the result register
// loads. The input stalls until then, so a new transfer is taken only after
// the last operation has loaded its result. Reset empties the table at once.
// ----------------------------------------------------------------------------
module sorted_key_table_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [2:0]                      i_mode,
    input  wire logic [skt_pkg::KEY_BITS-1:0]     i_key,
    input  wire logic [skt_pkg::POS_BITS-1:0]     i_position,
    input  wire logic [skt_pkg::PAYLOAD_BITS-1:0] i_payload,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [1:0]                      o_status,
    output logic                                 o_hit,
    output logic      [skt_pkg::POS_BITS-1:0]     o_where_found,
    output logic      [skt_pkg::KEY_BITS-1:0]     o_key_out,
    output logic      [skt_pkg::PAYLOAD_BITS-1:0] o_payload_out,
    output logic      [skt_pkg::CNT_BITS-1:0]     o_entry_count
);
    import skt_pkg::*;

    logic                    r_busy;
    logic [CNT_BITS-1:0]     r_count;
    t_mode                   r_mode;
    logic [KEY_BITS-1:0]     r_key;
    logic [POS_BITS-1:0]     r_position;
    logic [PAYLOAD_BITS-1:0] r_payload;

    logic                    r_out_valid;
    t_status                 r_status;
    logic                    r_hit;
    logic [POS_BITS-1:0]     r_where;
    logic [KEY_BITS-1:0]     r_key_out;
    logic [PAYLOAD_BITS-1:0] r_payload_out;
    logic [CNT_BITS-1:0]     r_count_out;

    t_status                 n_status;
    logic                    n_hit;
    logic [POS_BITS-1:0]     n_where;
    logic [KEY_BITS-1:0]     n_key_out;
    logic [PAYLOAD_BITS-1:0] n_payload_out;
    logic [CNT_BITS-1:0]     n_count;

    logic                    w_accept;
    logic                    w_done;
    logic [KEY_BITS-1:0]     w_cell_key [DEPTH];
    logic [PAYLOAD_BITS-1:0] w_cell_pl  [DEPTH];
    t_cell_flags             w_flags    [DEPTH];
    t_cell_ctl               w_ctl      [DEPTH];
    t_cell_cmd               w_cmd      [DEPTH];
    logic [DEPTH-1:0]        w_lt;
    logic [DEPTH-1:0]        w_eq;
    logic [DEPTH-1:0]        w_edge;
    logic                    w_found;
    logic [POS_BITS-1:0]     w_hit_pos;
    logic [POS_BITS-1:0]     w_ins_pos;
    logic [KEY_BITS-1:0]     w_hit_key;
    logic [PAYLOAD_BITS-1:0] w_hit_pl;
    logic                    w_pos_ok;
    logic                    w_full;

    assign w_accept = i_in_valid && !r_busy;
    assign w_done   = r_busy && (!r_out_valid || !i_out_stall);

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_lt[i] = w_flags[i].lt;
            w_eq[i] = w_flags[i].eq;
        end
        w_edge[0] = !w_lt[0];
        for (int i = 1; i < DEPTH; i++) begin
            w_edge[i] = !w_lt[i] && w_lt[i-1];
        end
        w_hit_key = '0;
        w_hit_pl  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_hit_key = w_hit_key | (w_cell_key[i] & {KEY_BITS{w_eq[i]}});
            w_hit_pl  = w_hit_pl  | (w_cell_pl[i]  & {PAYLOAD_BITS{w_eq[i]}});
        end
    end

    assign w_found   = |w_eq;
    assign w_hit_pos = f_onehot_enc(w_eq);
    assign w_ins_pos = f_onehot_enc(w_edge);
    assign w_pos_ok  = {1'b0, r_position} < r_count;
    assign w_full    = r_count == CNT_BITS'(DEPTH);

    always_comb begin
        n_status      = ST_OK;
        n_hit         = 1'b0;
        n_where       = '0;
        n_key_out     = '0;
        n_payload_out = '0;
        n_count       = r_count;
        for (int i = 0; i < DEPTH; i++) begin
            w_cmd[i] = CELL_HOLD;
        end
        unique case (r_mode)
            MODE_PUT: begin
                if (w_found) begin
                    n_hit         = 1'b1;
                    n_where       = w_hit_pos;
                    n_key_out     = r_key;
                    n_payload_out = r_payload;
                    for (int i = 0; i < DEPTH; i++) begin
                        w_cmd[i] = w_eq[i] ? CELL_SET_PAYLOAD : CELL_HOLD;
                    end
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_where       = w_ins_pos;
                    n_key_out     = r_key;
                    n_payload_out = r_payload;
                    n_count       = r_count + CNT_BITS'(1);
                    for (int i = 0; i < DEPTH; i++) begin
                        if (w_lt[i]) begin
                            w_cmd[i] = CELL_HOLD;
                        end else if (w_edge[i]) begin
                            w_cmd[i] = CELL_LOAD_NEW;
                        end else begin
                            w_cmd[i] = CELL_FROM_LEFT;
                        end
                    end
                end
            end
            MODE_FIND, MODE_RM_KEY: begin
                if (w_found) begin
                    n_hit         = 1'b1;
                    n_where       = w_hit_pos;
                    n_key_out     = w_hit_key;
                    n_payload_out = w_hit_pl;
                    if (r_mode == MODE_RM_KEY) begin
                        n_count = r_count - CNT_BITS'(1);
                        for (int i = 0; i < DEPTH; i++) begin
                            w_cmd[i] = w_lt[i] ? CELL_HOLD : CELL_FROM_RIGHT;
                        end
                    end
                end else begin
                    n_status = ST_NOKEY;
                end
            end
            MODE_READ, MODE_RM_POS: begin
                if (w_pos_ok) begin
                    n_where       = r_position;
                    n_key_out     = w_cell_key[r_position];
                    n_payload_out = w_cell_pl[r_position];
                    if (r_mode == MODE_RM_POS) begin
                        n_count = r_count - CNT_BITS'(1);
                        for (int i = 0; i < DEPTH; i++) begin
                            w_cmd[i] = (POS_BITS'(i) >= r_position) ? CELL_FROM_RIGHT
                                                                    : CELL_HOLD;
                        end
                    end
                end else begin
                    n_status = ST_BOUNDS;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_ctl[i].cmd    = w_done ? w_cmd[i] : CELL_HOLD;
            w_ctl[i].cmp_en = w_accept;
            w_ctl[i].valid  = CNT_BITS'(i) < r_count;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KEY_BITS-1:0]     w_left_key;
        logic [PAYLOAD_BITS-1:0] w_left_pl;
        logic [KEY_BITS-1:0]     w_right_key;
        logic [PAYLOAD_BITS-1:0] w_right_pl;

        if (g == 0) begin : g_first
            assign w_left_key = w_cell_key[g];
            assign w_left_pl  = w_cell_pl[g];
        end else begin : g_mid_l
            assign w_left_key = w_cell_key[g-1];
            assign w_left_pl  = w_cell_pl[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_key = w_cell_key[g];
            assign w_right_pl  = w_cell_pl[g];
        end else begin : g_mid_r
            assign w_right_key = w_cell_key[g+1];
            assign w_right_pl  = w_cell_pl[g+1];
        end

        skt_cell u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctl           (w_ctl[g]),
            .i_cmp_key       (i_key),
            .i_new_key       (r_key),
            .i_new_payload   (r_payload),
            .i_left_key      (w_left_key),
            .i_left_payload  (w_left_pl),
            .i_right_key     (w_right_key),
            .i_right_payload (w_right_pl),
            .o_key           (w_cell_key[g]),
            .o_payload       (w_cell_pl[g]),
            .o_flags         (w_flags[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode     <= t_mode'(i_mode);
            r_key      <= i_key;
            r_position <= i_position;
            r_payload  <= i_payload;
        end
        if (w_done) begin
            r_status      <= n_status;
            r_hit         <= n_hit;
            r_where       <= n_where;
            r_key_out     <= n_key_out;
            r_payload_out <= n_payload_out;
            r_count_out   <= n_count;
        end
    end

    assign o_in_stall    = r_busy;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_hit         = r_hit;
    assign o_where_found = r_where;
    assign o_key_out     = r_key_out;
    assign o_payload_out = r_payload_out;
    assign o_entry_count = r_count_out;

endmodule
`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// Sorted key table core testbench
// Drives put, find, read and remove operations through the valid/stall input
// channel while the result channel stalls at random and twice holds off for a
// long stretch. A scoreboard keeps its own sorted copy of the table, predicts
// every result, and checks each result field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skt_pkg::*;

    localparam logic [2:0] MODE_TOP = 3'b111;

    typedef struct packed {
        t_status                 status;
        logic                    hit;
        logic [POS_BITS-1:0]     where_found;
        logic [KEY_BITS-1:0]     key_out;
        logic [PAYLOAD_BITS-1:0] payload_out;
        logic [CNT_BITS-1:0]     entry_count;
    } table_result_t;

    typedef enum {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_HOLD} rx_style_t;

    class key_table_scoreboard;
        logic [KEY_BITS-1:0]     keys     [DEPTH];
        logic [PAYLOAD_BITS-1:0] payloads [DEPTH];
        int unsigned             used;
        table_result_t           pending  [$];
        int unsigned             errors;
        int unsigned             checked;
        int unsigned             mode_hits [8];
        int unsigned             full_refusals;
        int unsigned             replacements;
        int unsigned             peak;

        function int unsigned keys_below(logic [KEY_BITS-1:0] k);
            int unsigned n;
            n = 0;
            for (int unsigned i = 0; i < used; i++) begin
                if (keys[i] < k) begin
                    n++;
                end
            end
            return n;
        endfunction

        function void drop_entry(int unsigned p);
            for (int unsigned i = p; i + 1 < used; i++) begin
                keys[i]     = keys[i + 1];
                payloads[i] = payloads[i + 1];
            end
            used--;
        endfunction

        function void note_op(logic [2:0] mode, logic [KEY_BITS-1:0] key,
                              logic [POS_BITS-1:0] pos, logic [PAYLOAD_BITS-1:0] payload);
            table_result_t r;
            int unsigned   p;
            r = '0;
            mode_hits[mode]++;
            case (mode)
                MODE_PUT: begin
                    p = keys_below(key);
                    if (p < used && keys[p] == key) begin
                        payloads[p] = payload;
                        r.hit = 1'b1;
                        replacements++;
                    end else if (used >= DEPTH) begin
                        r.status = ST_FULL;
                        full_refusals++;
                    end else begin
                        for (int unsigned i = used; i > p; i--) begin
                            keys[i]     = keys[i - 1];
                            payloads[i] = payloads[i - 1];
                        end
                        keys[p]     = key;
                        payloads[p] = payload;
                        used++;
                    end
                    if (r.status == ST_OK) begin
                        r.where_found = POS_BITS'(p);
                        r.key_out     = key;
                        r.payload_out = payload;
                    end
                end
                MODE_FIND, MODE_RM_KEY: begin
                    p = keys_below(key);
                    if (p < used && keys[p] == key) begin
                        r.hit         = 1'b1;
                        r.where_found = POS_BITS'(p);
                        r.key_out     = keys[p];
                        r.payload_out = payloads[p];
                        if (mode == MODE_RM_KEY) begin
                            drop_entry(p);
                        end
                    end else begin
                        r.status = ST_NOKEY;
                    end
                end
                MODE_READ, MODE_RM_POS: begin
                    if (pos < used) begin
                        r.where_found = pos;
                        r.key_out     = keys[pos];
                        r.payload_out = payloads[pos];
                        if (mode == MODE_RM_POS) begin
                            drop_entry(pos);
                        end
                    end else begin
                        r.status = ST_BOUNDS;
                    end
                end
                default: begin
                end
            endcase
            if (used > peak) begin
                peak = used;
            end
            r.entry_count = CNT_BITS'(used);
            pending.push_back(r);
        endfunction

        task log_mismatch(string what);
            errors++;
            if (errors <= 40) begin
                $display("%0t ns mismatch: %s", $time, what);
            end
        endtask

        task check_result(table_result_t got);
            table_result_t want;
            if (pending.size() == 0) begin
                log_mismatch("result transfer with no operation outstanding");
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.status !== want.status)
                log_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.hit !== want.hit)
                log_mismatch($sformatf("hit %0b, expected %0b", got.hit, want.hit));
            if (got.where_found !== want.where_found)
                log_mismatch($sformatf("where_found %0d, expected %0d",
                                       got.where_found, want.where_found));
            if (got.key_out !== want.key_out)
                log_mismatch($sformatf("key_out %h, expected %h", got.key_out, want.key_out));
            if (got.payload_out !== want.payload_out)
                log_mismatch($sformatf("payload_out %h, expected %h",
                                       got.payload_out, want.payload_out));
            if (got.entry_count !== want.entry_count)
                log_mismatch($sformatf("entry_count %0d, expected %0d",
                                       got.entry_count, want.entry_count));
        endtask
    endclass

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_in_valid   = 1'b0;
    logic                    o_in_stall;
    logic [2:0]              i_mode       = '0;
    logic [KEY_BITS-1:0]     i_key        = '0;
    logic [POS_BITS-1:0]     i_position   = '0;
    logic [PAYLOAD_BITS-1:0] i_payload    = '0;
    logic                    o_out_valid;
    logic                    i_out_stall  = 1'b0;
    logic [1:0]              o_status;
    logic                    o_hit;
    logic [POS_BITS-1:0]     o_where_found;
    logic [KEY_BITS-1:0]     o_key_out;
    logic [PAYLOAD_BITS-1:0] o_payload_out;
    logic [CNT_BITS-1:0]     o_entry_count;

    key_table_scoreboard sb = new();
    int unsigned         burst_left;

    sorted_key_table_core DUT (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Both channels are sampled here, at the edge where a transfer happens.
    always @(posedge i_clk) begin : monitor
        table_result_t got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_op(i_mode, i_key, i_position, i_payload);
            end
            if (o_out_valid && !i_out_stall) begin
                got.status      = t_status'(o_status);
                got.hit         = o_hit;
                got.where_found = o_where_found;
                got.key_out     = o_key_out;
                got.payload_out = o_payload_out;
                got.entry_count = o_entry_count;
                sb.check_result(got);
            end
        end
    end

    initial begin : result_stall
        int unsigned seg;
        int unsigned len;
        rx_style_t   style;
        seg = 0;
        forever begin
            if (seg == 3 || seg == 9) begin
                style = RX_HOLD;
                len   = 90;
            end else begin
                style = rx_style_t'($urandom_range(int'(RX_FLOW), int'(RX_HEAVY)));
                len   = $urandom_range(10, 60);
            end
            for (int unsigned c = 0; c < len; c++) begin
                @(posedge i_clk);
                case (style)
                    RX_FLOW:  i_out_stall <= 1'b0;
                    RX_LIGHT: i_out_stall <= ($urandom_range(0, 99) < 30);
                    RX_HEAVY: i_out_stall <= ($urandom_range(0, 99) < 70);
                    default:  i_out_stall <= 1'b1;
                endcase
            end
            seg++;
        end
    end

    task automatic send_op(input logic [2:0] mode, input logic [KEY_BITS-1:0] key,
                           input logic [POS_BITS-1:0] pos,
                           input logic [PAYLOAD_BITS-1:0] payload);
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_key      <= key;
        i_position <= pos;
        i_payload  <= payload;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic send_random_op(input int unsigned put_pct, output bit counted);
        logic [2:0]              mode;
        logic [KEY_BITS-1:0]     key;
        logic [POS_BITS-1:0]     pos;
        int unsigned             roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            mode = 3'($urandom_range(int'(MODE_RM_KEY) + 1, int'(MODE_TOP)));
        end else if (roll < 3 + put_pct) begin
            mode = MODE_PUT;
        end else begin
            mode = 3'($urandom_range(int'(MODE_FIND), int'(MODE_RM_KEY)));
        end
        roll = $urandom_range(0, 99);
        if (roll < 45 && sb.used > 0) begin
            key = sb.keys[$urandom_range(0, sb.used - 1)];
        end else if (roll < 55) begin
            key = roll[0] ? '1 : '0;
        end else begin
            key = KEY_BITS'($urandom);
        end
        if (sb.used > 0 && $urandom_range(0, 99) < 70) begin
            pos = POS_BITS'($urandom_range(0, sb.used - 1));
        end else begin
            pos = POS_BITS'($urandom);
        end
        send_op(mode, key, pos, PAYLOAD_BITS'($urandom));
        counted = (mode <= MODE_RM_KEY);
    endtask

    initial begin : stimulus
        int unsigned put_mix [7];
        int unsigned done_ops;
        int unsigned step;
        bit          counted;
        put_mix  = '{85, 40, 15, 60, 90, 25, 50};
        done_ops = 0;
        step     = 0;
        burst_left = $urandom_range(1, 24);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table, then a few entries at the key extremes.
        send_op(MODE_READ, '0, '0, '0);
        send_op(MODE_FIND, '0, '0, '0);
        send_op(MODE_RM_KEY, '0, '0, '0);
        send_op(MODE_RM_POS, '0, '1, '0);
        send_op(MODE_PUT, 16'h8000, '0, '0);
        send_op(MODE_PUT, '0, '0, '1);
        send_op(MODE_PUT, '1, '1, 32'hA5A5_A5A5);
        send_op(MODE_PUT, 16'h8000, '0, 32'h5A5A_5A5A);
        send_op(MODE_FIND, '1, '0, '0);
        send_op(MODE_FIND, 16'h1234, '0, '0);
        send_op(MODE_READ, '0, 6'd2, '0);
        send_op(MODE_READ, '0, 6'd3, '0);
        send_op(MODE_READ, '0, '1, '0);
        send_op(MODE_RM_POS, '0, 6'd1, '0);
        send_op(MODE_RM_KEY, '0, '0, '0);
        send_op(MODE_RM_KEY, '0, '0, '0);
        for (int m = int'(MODE_RM_KEY) + 1; m <= int'(MODE_TOP); m++) begin
            send_op(3'(m), KEY_BITS'($urandom), POS_BITS'($urandom), PAYLOAD_BITS'($urandom));
        end
        send_op(MODE_PUT, 16'h7FFF, '0, 32'h0000_FFFF);
        send_op(MODE_RM_POS, '0, '0, '0);
        send_op(MODE_RM_POS, '0, '0, '0);

        // Phases alternate between filling the table and draining it.
        while (done_ops < 700) begin
            send_random_op(put_mix[(step / 100) % 7], counted);
            step++;
            if (counted) begin
                done_ops++;
            end
        end
        i_in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Operations: %0d put, %0d find, %0d read, %0d remove by position, %0d remove by key, %0d unused mode.",
                 sb.mode_hits[MODE_PUT], sb.mode_hits[MODE_FIND], sb.mode_hits[MODE_READ],
                 sb.mode_hits[MODE_RM_POS], sb.mode_hits[MODE_RM_KEY],
                 sb.mode_hits[5] + sb.mode_hits[6] + sb.mode_hits[7]);
        $display("Checked %0d results; peak of %0d entries, %0d full-table refusals, %0d payload replacements.",
                 sb.checked, sb.peak, sb.full_refusals, sb.replacements);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #2ms;
        $display("Timed out with %0d results outstanding.", sb.pending.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
src/skt_pkg.sv
src/skt_cell.sv
src/sorted_key_table_core.sv
sim/tb.sv
